[rtl/delayed_clock_schmitt_qualifier_macros.svh]
//------------------------------------------------------------------------------
// Assertion macros for the delayed clock Schmitt qualifier
// Concurrent assertion helpers that can be compiled out with NO_ASSERTIONS.
//------------------------------------------------------------------------------
`ifndef DELAYED_CLOCK_SCHMITT_QUALIFIER_MACROS_SVH
`define DELAYED_CLOCK_SCHMITT_QUALIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define DCSQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcsq assertion failed");

// Next-cycle implication, checked outside reset.
`define DCSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcsq assertion failed");

`else

`define DCSQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DCSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/dcsq_pkg.sv]
//------------------------------------------------------------------------------
// dcsq_pkg
// Shared widths, constants and register map of the delayed clock qualifier.
//------------------------------------------------------------------------------
`default_nettype none

package dcsq_pkg;

    // Longest delay in ticks; the ring holds one entry more.
    localparam int MAX_DELAY = 63;
    localparam int RING_LEN  = MAX_DELAY + 1;
    localparam int PTR_W     = (RING_LEN > 1) ? $clog2(RING_LEN) : 1;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 6;
    localparam int WIN_W     = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // Register indexes (byte address = 4 * index).
    typedef enum logic [2:0] {
        REG_IGNORE_FIRST = 3'd0,
        REG_DELAY_TICKS  = 3'd1,
        REG_THRESH_LOW   = 3'd2,
        REG_THRESH_HIGH  = 3'd3,
        REG_RESET_WINDOW = 3'd4
    } reg_idx_t;

    // Register reset values.
    localparam logic                       RST_IGNORE_FIRST = 1'b1;
    localparam logic        [DELAY_W-1:0]  RST_DELAY_TICKS  = 6'd2;
    localparam logic signed [SAMPLE_W-1:0] RST_THRESH_LOW   = 16'sd205;
    localparam logic signed [SAMPLE_W-1:0] RST_THRESH_HIGH  = 16'sd2048;
    localparam logic        [WIN_W-1:0]    RST_RESET_WINDOW = 16'd48;

endpackage

`default_nettype wire

[rtl/delayed_clock_schmitt_qualifier.sv]
//------------------------------------------------------------------------------
// delayed_clock_schmitt_qualifier
// Delays a sampled clock through a ring memory, squares it with a Schmitt trigger
// and, with ignore-first on, swallows the first rising edge after a reset event.
//------------------------------------------------------------------------------
//
//  Channel   Direction  Ports                                   Carries
//  s_        in         s_valid/s_ready, s_clock_sample,        one clock sample
//                       s_reset_event                           per transaction
//  m_        out        m_valid/m_ready, m_clock_gate           one gate level
//  APB       in/out     psel, penable, pwrite, paddr, pwdata,   five config regs
//                       prdata, pready
//
//  Each transaction goes through the read stage and then the output
//  register, and a new one is accepted every cycle unless both are full: the
//  ring is written and read in the accept cycle, and the registered read feeds
//  the Schmitt and window logic as it leaves. A stalled output only holds off
//  the input once both the read stage and the output register are full.
//  Reset (aresetn low, synchronous) empties the pipeline and clears one valid
//  flag per ring entry, so the ring reads as all zero at once; no clearing
//  pass is needed.
//
`default_nettype none

`include "delayed_clock_schmitt_qualifier_macros.svh"

module delayed_clock_schmitt_qualifier
    import dcsq_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_clock_sample,
    input  wire logic                       s_reset_event,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_clock_gate,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_AW-1:0]          paddr,
    input  wire logic [APB_DW-1:0]          pwdata,
    output logic      [APB_DW-1:0]          prdata,
    output logic                            pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                       ignore_first_reg, ignore_first_next;
    logic        [DELAY_W-1:0]  delay_ticks_reg,  delay_ticks_next;
    logic signed [SAMPLE_W-1:0] thresh_low_reg,   thresh_low_next;
    logic signed [SAMPLE_W-1:0] thresh_high_reg,  thresh_high_next;
    logic        [WIN_W-1:0]    reset_window_reg, reset_window_next;

    logic     cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    // A write to an index beyond the list falls into the default arm and is dropped.
    always_comb begin
        ignore_first_next = ignore_first_reg;
        delay_ticks_next  = delay_ticks_reg;
        thresh_low_next   = thresh_low_reg;
        thresh_high_next  = thresh_high_reg;
        reset_window_next = reset_window_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                REG_IGNORE_FIRST: ignore_first_next = pwdata[0];
                REG_DELAY_TICKS:  delay_ticks_next  = pwdata[DELAY_W-1:0];
                REG_THRESH_LOW:   thresh_low_next   = signed'(pwdata[SAMPLE_W-1:0]);
                REG_THRESH_HIGH:  thresh_high_next  = signed'(pwdata[SAMPLE_W-1:0]);
                REG_RESET_WINDOW: reset_window_next = pwdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Signed thresholds read back sign-extended.
    always_comb begin
        case (cfg_idx)
            REG_IGNORE_FIRST: prdata = {{(APB_DW-1){1'b0}}, ignore_first_reg};
            REG_DELAY_TICKS:  prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_ticks_reg};
            REG_THRESH_LOW:   prdata = {{(APB_DW-SAMPLE_W){thresh_low_reg[SAMPLE_W-1]}},
                                        thresh_low_reg};
            REG_THRESH_HIGH:  prdata = {{(APB_DW-SAMPLE_W){thresh_high_reg[SAMPLE_W-1]}},
                                        thresh_high_reg};
            REG_RESET_WINDOW: prdata = {{(APB_DW-WIN_W){1'b0}}, reset_window_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    // Stage 1 holds a transaction whose ring read is in flight. It moves on
    // when the output register is empty or being emptied.
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_gate_reg;
    logic s_accept;
    logic s1_go;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign s_accept = s_valid && s_ready;

    assign m_valid      = out_valid_reg;
    assign m_clock_gate = out_gate_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Ring delay line
    // ------------------------------------------------------------------
    // The write pointer advances first, the new sample lands there, and the
    // delayed entry is read in the same cycle. A delay of zero would read
    // the entry being written, so that case takes the incoming sample
    // directly. Entries never written since reset read as zero through the
    // valid flags.
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [RING_LEN-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0]    wp_adv;
    logic [PTR_W-1:0]    dly;
    logic [PTR_W-1:0]    rd_addr;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign wp_adv = (wp_reg == PTR_W'(RING_LEN - 1)) ? '0 : wp_reg + 1'b1;
    assign dly    = (int'(delay_ticks_reg) > MAX_DELAY) ? PTR_W'(MAX_DELAY)
                                                        : PTR_W'(delay_ticks_reg);
    assign rd_addr = (wp_adv >= dly) ? (wp_adv - dly)
                                     : PTR_W'(int'(wp_adv) + RING_LEN - int'(dly));

    always_comb begin
        wp_next    = wp_reg;
        valid_next = valid_reg;
        if (s_accept) begin
            wp_next            = wp_adv;
            valid_next[wp_adv] = 1'b1;
        end
    end

    dcsq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .clk   (aclk),
        .we    (s_accept),
        .waddr (wp_adv),
        .wdata (s_clock_sample),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Stage 1 side information captured with the read.
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic                       s1_fwd_reg;
    logic                       s1_hit_reg;
    logic                       s1_rst_ev_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_sample_reg <= s_clock_sample;
            s1_fwd_reg    <= (dly == '0);
            s1_hit_reg    <= valid_reg[rd_addr];
            s1_rst_ev_reg <= s_reset_event;
        end
    end

    // ------------------------------------------------------------------
    // Schmitt trigger, gate and swallow window
    // ------------------------------------------------------------------
    logic                       schmitt_reg, schmitt_next;
    logic                       gate_reg, gate_next;
    logic        [WIN_W-1:0]    window_reg, window_next;
    logic signed [SAMPLE_W-1:0] line;
    logic                       rise_ev;
    logic                       fall_ev;
    logic        [WIN_W-1:0]    window_mid;

    always_comb begin
        if (s1_fwd_reg) begin
            line = s1_sample_reg;
        end else if (s1_hit_reg) begin
            line = signed'(ram_rdata);
        end else begin
            line = '0;
        end
    end

    assign rise_ev = !schmitt_reg && (line >= thresh_high_reg);
    assign fall_ev =  schmitt_reg && (line <= thresh_low_reg);

    always_comb begin
        schmitt_next = schmitt_reg;
        gate_next    = gate_reg;
        window_next  = window_reg;
        window_mid   = window_reg;
        if (s1_go) begin
            // A rising edge inside an open window is eaten and shuts it.
            if (rise_ev) begin
                schmitt_next = 1'b1;
                if (window_reg == '0) begin
                    gate_next = 1'b1;
                end else begin
                    window_mid = '0;
                end
            end else if (fall_ev) begin
                schmitt_next = 1'b0;
                gate_next    = 1'b0;
            end

            window_next = (window_mid != '0) ? window_mid - 1'b1 : '0;

            // The reset event arms the window only after this tick's edge handling.
            if (s1_rst_ev_reg && ignore_first_reg) begin
                window_next = reset_window_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ignore_first_reg <= RST_IGNORE_FIRST;
            delay_ticks_reg  <= RST_DELAY_TICKS;
            thresh_low_reg   <= RST_THRESH_LOW;
            thresh_high_reg  <= RST_THRESH_HIGH;
            reset_window_reg <= RST_RESET_WINDOW;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            wp_reg           <= '0;
            valid_reg        <= '0;
            schmitt_reg      <= 1'b1;
            gate_reg         <= 1'b0;
            window_reg       <= '0;
        end else begin
            ignore_first_reg <= ignore_first_next;
            delay_ticks_reg  <= delay_ticks_next;
            thresh_low_reg   <= thresh_low_next;
            thresh_high_reg  <= thresh_high_next;
            reset_window_reg <= reset_window_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            wp_reg           <= wp_next;
            valid_reg        <= valid_next;
            schmitt_reg      <= schmitt_next;
            gate_reg         <= gate_next;
            window_reg       <= window_next;
        end
    end

    // The output register carries the gate as it stands after the transaction.
    always_ff @(posedge aclk) begin
        if (s1_go) begin
            out_gate_reg <= gate_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The input is only held off when both pipeline places are occupied.
    `DCSQ_ASSERT_SAME(a_stall_only_when_full, aclk, aresetn, !s_ready,
                      s1_valid_reg && out_valid_reg)
    // A transaction leaving the read stage always lands in the output register.
    `DCSQ_ASSERT_NEXT(a_go_fills_output, aclk, aresetn, s1_go, out_valid_reg)
    // The gate only turns on through an accepted rising event.
    `DCSQ_ASSERT_SAME(a_gate_rise_cause, aclk, aresetn, $rose(gate_reg),
                      $past(s1_go && rise_ev))
    // A swallowed edge closes the window unless a reset event rearms it.
    `DCSQ_ASSERT_NEXT(a_swallow_closes, aclk, aresetn,
                      s1_go && rise_ev && (window_reg != '0)
                          && !(s1_rst_ev_reg && ignore_first_reg),
                      window_reg == '0)

endmodule

`default_nettype wire

[rtl/dcsq_ram.sv]
//------------------------------------------------------------------------------
// dcsq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module dcsq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when read and write hit the same entry.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[bench/tb_delayed_clock_schmitt_qualifier.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Testbench for the delayed clock Schmitt qualifier
// Feeds clock samples and reset flags through the valid/ready input channel.
// Each gate level on the output channel is checked against a local model of
// the ring delay, Schmitt trigger and swallow window. The run starts with a
// short table of directed transactions and then moves through randomized
// phases under different register settings and idling patterns.
//------------------------------------------------------------------------------

module tb_delayed_clock_schmitt_qualifier
    import dcsq_pkg::*;
();

    // Index past the end of the register map. Writes to it must be ignored.
    localparam int REG_UNMAPPED = 7;

    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles the receiver holds off during the long back-pressure stretch.
    localparam int HOLD_CYCLES = 60;

    // One row of the directed table. Where "typed" is set, "gate" is the
    // level read straight off the behavior; otherwise the predictor decides.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       rev;
        logic                       typed;
        logic                       gate;
    } stim_row_t;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_clock_sample = '0;
    logic                       s_reset_event  = 1'b0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic                       m_clock_gate;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [APB_AW-1:0]          paddr          = '0;
    logic [APB_DW-1:0]          pwdata         = '0;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    delayed_clock_schmitt_qualifier DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_clock_sample (s_clock_sample),
        .s_reset_event  (s_reset_event),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_clock_gate   (m_clock_gate),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // The clock runs from time zero with a 20 ns period.
    initial begin
        forever #10 aclk = ~aclk;
    end

    //--------------------------------------------------------------------------
    // Local copy of the qualifier: register values and internal state.
    // The register copies start at the documented reset values.
    //--------------------------------------------------------------------------
    logic                       cfg_ignore = RST_IGNORE_FIRST;
    logic        [DELAY_W-1:0]  cfg_delay  = RST_DELAY_TICKS;
    logic signed [SAMPLE_W-1:0] cfg_tlo    = RST_THRESH_LOW;
    logic signed [SAMPLE_W-1:0] cfg_thi    = RST_THRESH_HIGH;
    logic        [WIN_W-1:0]    cfg_win    = RST_RESET_WINDOW;

    logic signed [SAMPLE_W-1:0] sample_ring [0:RING_LEN-1];
    int                         newest_pos   = 0;
    logic                       trig_high    = 1'b1;
    logic                       gate_now     = 1'b0;
    int                         swallow_left = 0;

    // Gate levels still owed by the block, oldest first.
    logic expected_gates [$];

    int mismatches  = 0;
    int cycle_count = 0;

    // Idling controls, set per phase by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The stimulus process bumps hold_req to ask for one long hold-off;
    // the receiver notices the change and runs the count itself.
    int hold_req = 0;

    // Square-wave state for the clock-like part of the random stimulus.
    bit level_hi = 1'b0;
    int run_left = 0;

    initial begin
        for (int i = 0; i < RING_LEN; i++) begin
            sample_ring[i] = '0;
        end
    end

    // Advances the local copy by one tick and returns the gate it predicts.
    // The ring is written first, so a delay of zero taps the sample that has
    // just been stored.
    function automatic logic predict_gate(input logic signed [SAMPLE_W-1:0] smp,
                                          input logic rev);
        int                         dly;
        logic signed [SAMPLE_W-1:0] tap;
        logic                       rising;
        logic                       falling;
        dly = (int'(cfg_delay) > MAX_DELAY) ? MAX_DELAY : int'(cfg_delay);
        newest_pos = (newest_pos + 1) % RING_LEN;
        sample_ring[newest_pos] = smp;
        tap = sample_ring[(newest_pos + RING_LEN - dly) % RING_LEN];
        rising  = 1'b0;
        falling = 1'b0;
        if (trig_high) begin
            if (tap <= cfg_tlo) begin
                trig_high = 1'b0;
                falling   = 1'b1;
            end
        end else begin
            if (tap >= cfg_thi) begin
                trig_high = 1'b1;
                rising    = 1'b1;
            end
        end
        // A rising edge inside an open window is swallowed and closes it.
        if (rising) begin
            if (swallow_left == 0) begin
                gate_now = 1'b1;
            end else begin
                swallow_left = 0;
            end
        end else if (falling) begin
            gate_now = 1'b0;
        end
        if (swallow_left > 0) begin
            swallow_left--;
        end
        // The window is armed after this tick's clock handling, and only
        // while the ignore-first-clock feature is on.
        if (rev && cfg_ignore) begin
            swallow_left = int'(cfg_win);
        end
        return gate_now;
    endfunction

    //--------------------------------------------------------------------------
    // Checking
    //--------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Output side: every edge first checks a transaction that completes there,
    // using the values that held before the edge, then decides whether the
    // receiver accepts during the next cycle.
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_gates.size() == 0) begin
                report_mismatch($sformatf("gate %0b arrived with no transaction pending",
                                          m_clock_gate));
            end else begin
                want = expected_gates.pop_front();
                if (m_clock_gate !== want) begin
                    report_mismatch($sformatf("clock_gate is %0b, expected %0b",
                                              m_clock_gate, want));
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_delayed_clock_schmitt_qualifier failed");
            $finish;
        end
    end

    //--------------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------------

    // One APB write: a setup phase, then an access phase held until pready.
    // The local register copy follows the write, with the same masking and
    // sign handling as the block; an index past the map changes nothing.
    task automatic apb_write(input int idx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IGNORE_FIRST: cfg_ignore = data[0];
            REG_DELAY_TICKS:  cfg_delay  = data[DELAY_W-1:0];
            REG_THRESH_LOW:   cfg_tlo    = data[SAMPLE_W-1:0];
            REG_THRESH_HIGH:  cfg_thi    = data[SAMPLE_W-1:0];
            REG_RESET_WINDOW: cfg_win    = data[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // Writes every register. The bits above each field are filled with
    // random junk, which the block has to ignore.
    task automatic load_settings(input logic ign, input logic [DELAY_W-1:0] dly,
                                 input int tlo, input int thi, input int win);
        apb_write(REG_IGNORE_FIRST, {31'($urandom), ign});
        apb_write(REG_DELAY_TICKS,  {26'($urandom), dly});
        apb_write(REG_THRESH_LOW,   {16'($urandom), 16'(tlo)});
        apb_write(REG_THRESH_HIGH,  {16'($urandom), 16'(thi)});
        apb_write(REG_RESET_WINDOW, {16'($urandom), 16'(win)});
    endtask

    //--------------------------------------------------------------------------
    // Input side
    //--------------------------------------------------------------------------

    // Offers one transaction and waits until it is taken. Random idle cycles
    // come first with valid low; once raised, valid and the payload hold
    // until the handshake. On acceptance the predictor is advanced and the
    // owed gate level is queued.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic rev,
                               input logic typed, input logic typed_gate);
        logic g;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_clock_sample <= smp;
        s_reset_event  <= rev;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        g = predict_gate(smp, rev);
        expected_gates.push_back(typed ? typed_gate : g);
    endtask

    // Lowers valid and waits until every owed gate level has come back, then
    // lets the two-stage pipeline settle before a register write.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_gates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // A sample inside the band that makes the trigger go high (at or above
    // the rising threshold) or low (at or below the falling threshold).
    function automatic logic signed [SAMPLE_W-1:0] band_sample(input bit want_high);
        int lo;
        int hi;
        if (want_high) begin
            lo = int'(cfg_thi);
            hi = 32767;
        end else begin
            lo = -32768;
            hi = int'(cfg_tlo);
        end
        return SAMPLE_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Mostly a square wave of random run lengths with random levels in the
    // switching bands, so that edges and the swallow window are exercised;
    // the rest is raw noise over the full 16-bit range. Reset events are
    // sprinkled in so that windows open, get reloaded and expire.
    task automatic random_phase(input int n_items, input int idle_pct,
                                input int stall_pct, input bit long_hold);
        logic signed [SAMPLE_W-1:0] smp;
        logic                       rev;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (long_hold) begin
            hold_req++;
        end
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                if (run_left == 0) begin
                    level_hi = !level_hi;
                    run_left = $urandom_range(1, 10);
                end
                run_left--;
                smp = band_sample(level_hi);
            end else begin
                smp = SAMPLE_W'($urandom);
            end
            rev = ($urandom_range(0, 99) < 5);
            send_sample(smp, rev, 1'b0, 1'b0);
        end
        drain_results();
    endtask

    //--------------------------------------------------------------------------
    // Directed table, run under the reset values of the registers (delay 2,
    // thresholds 205 and 2048, window 48, ignore-first-clock on). The first
    // rows are simple enough to state the gate directly: the ring reads as
    // zero after reset, and the first rising edge after the reset flag lands
    // inside the window and is swallowed. The remaining rows cover samples
    // exactly at and just past each threshold, a reset flag while the window
    // is closed and another while it is still open, both field extremes, and
    // alternating bit patterns.
    //--------------------------------------------------------------------------
    stim_row_t dir_rows [0:22] = '{
        '{16'sd0,     1'b0, 1'b1, 1'b0},
        '{16'sd32767, 1'b1, 1'b1, 1'b0},
        '{16'sd32767, 1'b0, 1'b1, 1'b0},
        '{16'sh8000,  1'b0, 1'b1, 1'b0},
        '{16'sh8000,  1'b0, 1'b0, 1'b0},
        '{16'sd205,   1'b0, 1'b0, 1'b0},
        '{16'sd2047,  1'b0, 1'b0, 1'b0},
        '{16'sd2048,  1'b1, 1'b0, 1'b0},
        '{16'sd205,   1'b1, 1'b0, 1'b0},
        '{16'sd206,   1'b0, 1'b0, 1'b0},
        '{16'sd0,     1'b0, 1'b0, 1'b0},
        '{16'sd2048,  1'b0, 1'b0, 1'b0},
        '{16'sd2048,  1'b0, 1'b0, 1'b0},
        '{16'sd204,   1'b0, 1'b0, 1'b0},
        '{16'shFFFF,  1'b0, 1'b0, 1'b0},
        '{16'sh5555,  1'b0, 1'b0, 1'b0},
        '{16'shAAAA,  1'b0, 1'b0, 1'b0},
        '{16'sh5555,  1'b1, 1'b0, 1'b0},
        '{16'sd32767, 1'b0, 1'b0, 1'b0},
        '{16'sd32767, 1'b0, 1'b0, 1'b0},
        '{16'sd0,     1'b0, 1'b0, 1'b0},
        '{16'sd0,     1'b0, 1'b0, 1'b0},
        '{16'sd2048,  1'b0, 1'b0, 1'b0}
    };

    //--------------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------------
    initial begin
        // Reset is held low from time zero and released once. The block needs no
        // clearing pass, so traffic starts right after.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows go in back to back with the receiver always ready.
        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].smp, dir_rows[i].rev,
                        dir_rows[i].typed, dir_rows[i].gate);
        end
        drain_results();

        // Delay zero taps the sample just written; a short window.
        load_settings(1'b1, 6'd0, 205, 2048, 8);
        random_phase(100, 0, 0, 1'b0);

        // Longest delay, widest thresholds and longest window. The receiver
        // also holds off for a long stretch here while the sender keeps
        // offering, so the pipeline fills and the input stalls.
        load_settings(1'b1, 6'd63, -32768, 32767, 65535);
        random_phase(100, 0, 0, 1'b1);

        // Ignore-first-clock off: reset flags must leave the window alone.
        load_settings(1'b0, 6'd5, -1000, 1000, 0);
        random_phase(100, 79, 0, 1'b0);

        // Thresholds in the wrong order with a zero-length window.
        load_settings(1'b1, 6'd1, 3000, -3000, 0);
        random_phase(100, 0, 79, 1'b0);

        // Equal thresholds. A write past the register map goes first and
        // must leave every setting as it was.
        apb_write(REG_UNMAPPED, '0);
        load_settings(1'b1, 6'd17, 500, 500, 20);
        random_phase(100, 8, 8, 1'b0);

        // Thresholds inverted at the extremes, then the reset values again.
        load_settings(1'b1, 6'd63, 32767, -32768, 3);
        random_phase(50, 0, 0, 1'b0);
        load_settings(RST_IGNORE_FIRST, RST_DELAY_TICKS, int'(RST_THRESH_LOW),
                      int'(RST_THRESH_HIGH), int'(RST_RESET_WINDOW));
        random_phase(50, 0, 0, 1'b0);

        // Every transaction has been answered; give stray outputs a chance
        // to show up before the verdict.
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_delayed_clock_schmitt_qualifier passed");
        end else begin
            $display("tb_delayed_clock_schmitt_qualifier failed");
        end
        $finish;
    end

endmodule
